// ===== hw/rtl/frpm_pkg.sv =====
// Shared types and constants for the forward-or-reverse pattern matcher.
`timescale 1ns / 1ps

package frpm_pkg;

   // Pattern storage is two 64-bit registers, sixteen bytes in all.
   localparam int PATTERN_BYTES         = 16;
   localparam int LENGTH_BITS           = 5;
   localparam int CSR_DATA_BITS         = 64;
   localparam int CSR_ADDR_BITS         = 5;
   localparam int MATCH_START_BITS      = 16;
   localparam int MAX_PATTERN_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 16;

   // Register indexes, taken from paddr[4:3] (registers sit 8 bytes apart).
   localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
   localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;

   typedef logic [PATTERN_BYTES-1:0][7:0] pattern_type;

   typedef struct packed {
      logic fwd;
      logic rev;
   } cell_match_type;

endpackage

// ===== hw/rtl/frpm_csr.sv =====
// APB-style configuration registers: pattern length and pattern bytes.
`timescale 1ns / 1ps

module frpm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [frpm_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [frpm_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [frpm_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output logic [frpm_pkg::LENGTH_BITS-1:0]     pattern_length,
   output frpm_pkg::pattern_type                pattern
);

   logic [frpm_pkg::LENGTH_BITS-1:0]   length_ff;
   logic [frpm_pkg::CSR_DATA_BITS-1:0] low_ff;
   logic [frpm_pkg::CSR_DATA_BITS-1:0] high_ff;
   logic [1:0]                         index;
   logic                               wr_en;

   assign index = paddr[4:3];
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= frpm_pkg::LENGTH_BITS'(1);
         low_ff    <= '0;
         high_ff   <= '0;
      end else if (wr_en) begin
         unique case (index)
            frpm_pkg::REG_PATTERN_LENGTH: begin
               length_ff <= pwdata[frpm_pkg::LENGTH_BITS-1:0];
            end
            frpm_pkg::REG_PATTERN_LOW: begin
               low_ff <= pwdata;
            end
            frpm_pkg::REG_PATTERN_HIGH: begin
               high_ff <= pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         frpm_pkg::REG_PATTERN_LENGTH: begin
            prdata = frpm_pkg::CSR_DATA_BITS'(length_ff);
         end
         frpm_pkg::REG_PATTERN_LOW: begin
            prdata = low_ff;
         end
         frpm_pkg::REG_PATTERN_HIGH: begin
            prdata = high_ff;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign pattern_length = length_ff;
   assign pattern        = {high_ff, low_ff};

endmodule

// ===== hw/rtl/frpm_cell.sv =====
// One window cell: holds one text byte and checks the byte it loads.
`timescale 1ns / 1ps

module frpm_cell #(
   parameter int IDX = 0
) (
   input  logic                             clock,
   input  logic                             shift_en,
   input  logic [7:0]                       byte_in,
   input  frpm_pkg::pattern_type            pattern,
   input  logic [frpm_pkg::LENGTH_BITS-1:0] length,
   output logic [7:0]                       byte_out,
   output frpm_pkg::cell_match_type         match
);

   logic [7:0]                       byte_ff;
   logic [3:0]                       fwd_sel;
   logic                             active;

   // Cell IDX holds the byte IDX steps old. It lines up with pattern byte
   // length-1-IDX in the forward sense and pattern byte IDX reversed.
   assign active  = frpm_pkg::LENGTH_BITS'(IDX) < length;
   assign fwd_sel = 4'(length - frpm_pkg::LENGTH_BITS'(1) - frpm_pkg::LENGTH_BITS'(IDX));

   assign match.fwd = !active || (byte_in == pattern[fwd_sel]);
   assign match.rev = !active || (byte_in == pattern[IDX]);

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

// ===== hw/rtl/forward_or_reverse_pattern_matcher.sv =====
// Top level of the forward-or-reverse pattern matcher.
`timescale 1ns / 1ps

// Streams text one byte per beat through a row of MAX_PATTERN byte cells
// and reports each window of the last pattern_length bytes that equals the
// configured pattern (forward_match), the pattern read backwards
// (reverse_match), or both for a palindrome. A result beat carries the text
// position of the window's first byte. Throughput is one text byte per clock;
// every cell compares the byte it is loading in the accept cycle, so a result
// appears in the output register in the cycle after its byte is accepted. The
// output register is the only buffer: while a result waits for rsp_ready the
// next byte is still taken if the register is emptied in the same cycle,
// otherwise req_ready drops. end_of_text restarts position and window fill
// after its own byte is checked. Pattern length is read as 1 when written 0
// and as MAX_PATTERN when written larger. Registers (64-bit, 8 bytes apart):
// 0x00 pattern_length, 0x08 pattern bytes 0..7, 0x10 pattern bytes 8..15,
// byte 0 in the low bits. Write configuration only while the block is idle.
module forward_or_reverse_pattern_matcher #(
   parameter int MAX_PATTERN   = frpm_pkg::MAX_PATTERN_DEFAULT,
   parameter int POSITION_BITS = frpm_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // text input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_text_byte,
   input  logic                                  req_end_of_text,
   // match results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [frpm_pkg::MATCH_START_BITS-1:0] rsp_match_start,
   output logic                                  rsp_forward_match,
   output logic                                  rsp_reverse_match,
   // configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [frpm_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [frpm_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [frpm_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   localparam int SEEN_BITS = $clog2(MAX_PATTERN + 1);
   localparam int CMP_BITS  = frpm_pkg::LENGTH_BITS + 1;

   // ---- configuration ----
   logic [frpm_pkg::LENGTH_BITS-1:0] cfg_length;
   frpm_pkg::pattern_type            cfg_pattern;
   logic [frpm_pkg::LENGTH_BITS-1:0] length;

   frpm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .prdata         (csr_prdata),
      .pready         (csr_pready),
      .pattern_length (cfg_length),
      .pattern        (cfg_pattern)
   );

   // Clamp the written length to 1..MAX_PATTERN.
   always_comb begin
      priority if (cfg_length == '0) begin
         length = frpm_pkg::LENGTH_BITS'(1);
      end else if (cfg_length > frpm_pkg::LENGTH_BITS'(MAX_PATTERN)) begin
         length = frpm_pkg::LENGTH_BITS'(MAX_PATTERN);
      end else begin
         length = cfg_length;
      end
   end

   // ---- output register state ----
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [frpm_pkg::MATCH_START_BITS-1:0] start_ff;
   logic                                  fwd_ff;
   logic                                  rev_ff;

   // ---- handshake ----
   logic req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // ---- cell row: cell 0 takes the new byte, each cell feeds the next ----
   logic [MAX_PATTERN-1:0][7:0]           cell_byte;
   frpm_pkg::cell_match_type [MAX_PATTERN-1:0] cell_match;
   logic [MAX_PATTERN-1:0]                fwd_bits;
   logic [MAX_PATTERN-1:0]                rev_bits;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [7:0] shift_byte;

      if (k == 0) begin : g_head
         assign shift_byte = req_text_byte;
      end else begin : g_body
         assign shift_byte = cell_byte[k-1];
      end

      frpm_cell #(
         .IDX (k)
      ) u_cell (
         .clock    (clock),
         .shift_en (req_fire),
         .byte_in  (shift_byte),
         .pattern  (cfg_pattern),
         .length   (length),
         .byte_out (cell_byte[k]),
         .match    (cell_match[k])
      );

      assign fwd_bits[k] = cell_match[k].fwd;
      assign rev_bits[k] = cell_match[k].rev;
   end

   // ---- position and fill count ----
   logic [POSITION_BITS-1:0]              pos_ff, pos_in;
   logic [SEEN_BITS-1:0]                  seen_ff, seen_in, seen_next;
   logic                                  window_full;
   logic                                  fwd_hit, rev_hit, hit;
   logic [POSITION_BITS-1:0]              start_pos;
   logic [frpm_pkg::MATCH_START_BITS-1:0] start_out;

   assign seen_next   = (seen_ff < SEEN_BITS'(MAX_PATTERN)) ? seen_ff + SEEN_BITS'(1)
                                                            : seen_ff;
   assign window_full = CMP_BITS'(seen_next) >= CMP_BITS'(length);
   assign fwd_hit     = &fwd_bits;
   assign rev_hit     = &rev_bits;
   assign hit         = window_full && (fwd_hit || rev_hit);

   // Window start = current position - (length - 1), modulo the position width.
   assign start_pos = pos_ff - POSITION_BITS'(length - frpm_pkg::LENGTH_BITS'(1));
   assign start_out = frpm_pkg::MATCH_START_BITS'(start_pos);

   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      if (req_fire) begin
         if (req_end_of_text) begin
            pos_in  = '0;
            seen_in = '0;
         end else begin
            pos_in  = pos_ff + POSITION_BITS'(1);
            seen_in = seen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         seen_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
      end
   end

   // ---- output register ----
   always_comb begin
      priority if (req_fire) begin
         rsp_valid_in = hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && hit) begin
         start_ff <= start_out;
         fwd_ff   <= window_full && fwd_hit;
         rev_ff   <= window_full && rev_hit;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_start   = start_ff;
   assign rsp_forward_match = fwd_ff;
   assign rsp_reverse_match = rev_ff;

endmodule

// ===== sim/forward_or_reverse_pattern_matcher_tb.sv =====
// Testbench for the forward-or-reverse pattern matcher: scoreboard, drivers and stimulus.
`timescale 1ns / 1ps

module forward_or_reverse_pattern_matcher_tb;

   localparam int WINDOW = frpm_pkg::MAX_PATTERN_DEFAULT;
   localparam int POS_BITS = frpm_pkg::POSITION_BITS_DEFAULT;
   localparam int START_BITS = frpm_pkg::MATCH_START_BITS;
   // paddr[4:3] == 3 decodes to no register; writes there must be dropped
   localparam logic [1:0] REG_UNMAPPED = 2'd3;
   // result is registered after its byte is taken; the spare drain cycles cover it
   localparam int DRAIN_CYCLES = 4;
   localparam int SEGMENTS = 12;
   localparam int SEGMENT_BEATS = 110;

   typedef struct {
      logic [START_BITS-1:0] start;
      logic                  fwd;
      logic                  rev;
   } match_beat_type;

   // Predicts match beats from the text stream and checks the DUT against them.
   class match_scoreboard;
      logic [7:0]          window_bytes [WINDOW] = '{default: 8'h00};  // [0] is newest
      logic [POS_BITS-1:0] text_position = '0;
      logic [4:0]          window_fill = '0;
      logic [4:0]          length_reg = 5'd1;
      logic [127:0]        pattern_reg = '0;
      match_beat_type      expected_matches [$];
      int                  mismatches = 0;

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         mismatches++;
      endtask

      function logic [7:0] pattern_byte(int k);
         return pattern_reg[8*k +: 8];
      endfunction

      // out-of-range lengths clamp to 1..WINDOW
      function int active_length();
         if (length_reg == 0) return 1;
         if (length_reg > WINDOW) return WINDOW;
         return length_reg;
      endfunction

      function void write_reg(logic [1:0] index, logic [63:0] value);
         case (index)
            frpm_pkg::REG_PATTERN_LENGTH: length_reg = value[frpm_pkg::LENGTH_BITS-1:0];
            frpm_pkg::REG_PATTERN_LOW:    pattern_reg[63:0] = value;
            frpm_pkg::REG_PATTERN_HIGH:   pattern_reg[127:64] = value;
            default: ;
         endcase
      endfunction

      function void note_text(logic [7:0] text_byte, logic last);
         int             len;
         int             k;
         logic [7:0]     w;
         bit             fwd;
         bit             rev;
         match_beat_type beat;
         len = active_length();
         for (k = WINDOW - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
         window_bytes[0] = text_byte;
         if (window_fill < WINDOW) window_fill++;
         if (window_fill >= len) begin
            fwd = 1'b1;
            rev = 1'b1;
            for (k = 0; k < len; k++) begin
               w = window_bytes[len-1-k];
               if (w != pattern_byte(k)) fwd = 1'b0;
               if (w != pattern_byte(len-1-k)) rev = 1'b0;
            end
            if (fwd || rev) begin
               beat.start = START_BITS'(text_position - POS_BITS'(len - 1));
               beat.fwd = fwd;
               beat.rev = rev;
               expected_matches.push_back(beat);
            end
         end
         text_position++;
         if (last) begin
            text_position = '0;
            window_fill = '0;
         end
      endfunction

      task check_match(logic [START_BITS-1:0] start, logic fwd, logic rev);
         match_beat_type want;
         if (expected_matches.size() == 0) begin
            report($sformatf("unexpected beat start=%0d fwd=%b rev=%b", start, fwd, rev));
            return;
         end
         want = expected_matches.pop_front();
         if (start !== want.start)
            report($sformatf("match_start %0d, want %0d", start, want.start));
         if (fwd !== want.fwd)
            report($sformatf("forward_match %b, want %b (start %0d)", fwd, want.fwd, want.start));
         if (rev !== want.rev)
            report($sformatf("reverse_match %b, want %b (start %0d)", rev, want.rev, want.start));
      endtask

      task finish_check();
         if (expected_matches.size() != 0)
            report($sformatf("%0d match beats never arrived", expected_matches.size()));
      endtask
   endclass

   // ---------------------------------------------------------------- DUT I/O
   logic                                  clock;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic [7:0]                            req_text_byte = '0;
   logic                                  req_end_of_text = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic [START_BITS-1:0]                 rsp_match_start;
   logic                                  rsp_forward_match;
   logic                                  rsp_reverse_match;
   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [frpm_pkg::CSR_ADDR_BITS-1:0]    csr_paddr = '0;
   logic [frpm_pkg::CSR_DATA_BITS-1:0]    csr_pwdata = '0;
   logic [frpm_pkg::CSR_DATA_BITS-1:0]    csr_prdata;
   logic                                  csr_pready;

   match_scoreboard sb = new;
   int req_beats = 0;       // accepted text beats, advanced at the rising edge
   int send_idle_pct = 0;   // chance per cycle that the sender holds off
   int stall_pct = 0;       // chance per cycle that the receiver stalls

   forward_or_reverse_pattern_matcher u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_start   (rsp_match_start),
      .rsp_forward_match (rsp_forward_match),
      .rsp_reverse_match (rsp_reverse_match),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor: both channels sampled at the rising edge, before the DUT updates.
   // A result is registered only after its own byte is accepted, so order here is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_match(rsp_match_start, rsp_forward_match, rsp_reverse_match);
         if (req_valid && req_ready) begin
            sb.note_text(req_text_byte, req_end_of_text);
            req_beats <= req_beats + 1;
         end
      end
   end

   // ---------------------------------------------------------------- drivers
   // All drivers are entered and left just after a falling edge.

   // Setup then access cycle; the register takes the value at the rising edge that ends the access cycle.
   task automatic csr_write(logic [1:0] index, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.write_reg(index, value);
   endtask

   // One text beat. valid stays up between back-to-back beats; it only drops
   // while the sender idles.
   task automatic send_text(logic [7:0] text_byte, logic last);
      int target;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      target = req_beats + 1;
      req_valid       <= 1'b1;
      req_text_byte   <= text_byte;
      req_end_of_text <= last;
      do @(negedge clock); while (req_beats < target);
   endtask

   // Stop sending, let every predicted match come out, then wait out the spare
   // drain cycles for a byte that produced nothing.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_matches.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic random_last();
      return ($urandom_range(59) == 0);
   endfunction

   // Pick length and pattern for one segment; first few hit the length extremes.
   task automatic configure_segment(int seg);
      logic [4:0]   len_code;
      logic [127:0] pat;
      logic [63:0]  len_word;
      int           len;
      int           k;
      case (seg)
         0: len_code = 5'd1;
         1: len_code = 5'd16;
         2: len_code = 5'd0;        // reads as 1
         3: len_code = 5'd31;       // reads as MAX_PATTERN
         4: len_code = 5'd17;
         default: begin
            if ($urandom_range(3) == 0) len_code = 5'($urandom_range(31));
            else len_code = 5'($urandom_range(1, 16));
         end
      endcase
      len = (len_code == 0) ? 1 : (len_code > WINDOW) ? WINDOW : len_code;
      pat = {$urandom, $urandom, $urandom, $urandom};
      case (seg % 5)
         0: if (seg == 0) pat = '0;
         1: begin  // palindrome: every match is both ways
            for (k = 0; k < len / 2; k++) pat[8*(len-1-k) +: 8] = pat[8*k +: 8];
         end
         2: pat = '1;
         3: begin  // two-symbol alphabet, lots of overlapping partial matches
            for (k = 0; k < WINDOW; k++) pat[8*k +: 8] = {7'd0, pat[8*k]};
         end
         default: ;
      endcase
      // junk above the length field on odd segments; only bits 4:0 count
      len_word = (seg % 2 == 1) ? {$urandom, $urandom} : 64'd0;
      len_word[4:0] = len_code;
      csr_write(frpm_pkg::REG_PATTERN_LENGTH, len_word);
      csr_write(frpm_pkg::REG_PATTERN_LOW, pat[63:0]);
      csr_write(frpm_pkg::REG_PATTERN_HIGH, pat[127:64]);
   endtask

   // Mostly whole pattern copies (forward, reversed, sometimes one bit off),
   // padded with noise drawn from the pattern's own bytes or anything at all.
   task automatic send_segment(int beats);
      int         sent;
      int         len;
      int         kind;
      int         spoil;
      int         n;
      int         k;
      logic [7:0] b;
      len = sb.active_length();
      sent = 0;
      while (sent < beats) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            spoil = ($urandom_range(9) < 2) ? $urandom_range(len - 1) : -1;
            for (k = 0; k < len; k++) begin
               b = (kind < 45) ? sb.pattern_byte(k) : sb.pattern_byte(len - 1 - k);
               if (k == spoil) b = b ^ (8'd1 << $urandom_range(7));
               send_text(b, random_last());
            end
            sent += len;
         end else begin
            n = $urandom_range(1, len);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(9) < 6) b = sb.pattern_byte($urandom_range(len - 1));
               else b = 8'($urandom_range(255));
               send_text(b, random_last());
            end
            sent += n;
         end
      end
   endtask

   // ---------------------------------------------------------------- main
   initial begin
      int seg;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset config is length 1, pattern byte 0x00.
      send_text(8'h00, 1'b0);            // match at position 0, both ways
      send_text(8'hFF, 1'b0);
      send_text(8'h80, 1'b0);
      send_text(8'h00, 1'b1);            // matches on the last byte, then restart
      send_text(8'h00, 1'b0);            // position back at 0
      wait_drained();
      csr_write(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);   // must be ignored
      send_text(8'h00, 1'b0);
      wait_drained();

      csr_write(frpm_pkg::REG_PATTERN_LENGTH, 64'd3);
      csr_write(frpm_pkg::REG_PATTERN_LOW, 64'h0003_0201);
      send_text(8'h03, 1'b0);
      send_text(8'h02, 1'b0);
      send_text(8'h01, 1'b0);            // reversed pattern
      send_text(8'h02, 1'b0);
      send_text(8'h03, 1'b0);            // forward pattern, overlapping the last
      send_text(8'h7F, 1'b1);
      wait_drained();

      csr_write(frpm_pkg::REG_PATTERN_LOW, 64'h007E_817E);    // palindrome
      send_text(8'h7E, 1'b0);
      send_text(8'h81, 1'b0);
      send_text(8'h7E, 1'b1);
      wait_drained();

      // Random segments, cycling through the pressure modes.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         configure_segment(seg);
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         send_segment(SEGMENT_BEATS);
         wait_drained();
      end

      sb.finish_check();
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
